/* rtl/core/srfp_pkg.sv */
// srfp_pkg: types and constants for the servo reply frame parser
// no dependencies; imported by servo_reply_frame_parser
package srfp_pkg;

  // parser phase codes
  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_ID     = 3'd1,
    PH_LEN    = 3'd2,
    PH_STATUS = 3'd3,
    PH_PARAM  = 3'd4,
    PH_CSUM   = 3'd5
  } phase_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_SERVO_ID_0  = 3'd0,
    REG_SERVO_ID_1  = 3'd1,
    REG_SERVO_ID_2  = 3'd2,
    REG_SERVO_ID_3  = 3'd3,
    REG_POS_ADDRESS = 3'd4
  } reg_index_t;

  localparam int unsigned ID_SLOTS = 4;

  localparam logic [7:0]  HEADER_BYTE   = 8'hFF;
  localparam logic [15:0] BAD_COUNT_MAX = 16'hFFFF;
  localparam logic [7:0]  MIN_LENGTH    = 8'd2;

  localparam logic [7:0] SERVO_ID_0_RESET  = 8'd1;
  localparam logic [7:0] SERVO_ID_1_RESET  = 8'd2;
  localparam logic [7:0] SERVO_ID_2_RESET  = 8'd3;
  localparam logic [7:0] SERVO_ID_3_RESET  = 8'd4;
  localparam logic [7:0] POS_ADDRESS_RESET = 8'd56;

endpackage

/* rtl/core/servo_reply_frame_parser.sv */
// servo_reply_frame_parser: status frame parser for a half-duplex servo bus
// depends on srfp_pkg (phase codes, register indexes, constants)
// a request is taken into the input register and its result is then registered in the result register
// throughput: one request per cycle; the only stall comes from a held result
// a result is produced only for the checksum byte of a frame; other requests
// update parser state and give nothing
// reset (rst, synchronous): parser hunts for a header, counters and stored
// statuses and positions clear, ids and position address take defaults
module servo_reply_frame_parser
  import srfp_pkg::*;
#(
  parameter int unsigned NUM_SERVOS = 4
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [7:0]  rx_byte,
  input  logic        is_read_request,
  input  logic [7:0]  read_address,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        checksum_ok,
  output logic        was_echo,
  output logic        servo_matched,
  output logic [1:0]  servo_index,
  output logic [7:0]  servo_status,
  output logic        position_updated,
  output logic [15:0] position,
  output logic [15:0] failed_checksums,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int unsigned IDX_W = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;

  // configuration registers
  logic [7:0] servo_id [ID_SLOTS];
  logic [7:0] pos_address;

  // input register stage
  logic       s1_valid;
  logic       s1_mode;
  logic [7:0] s1_byte;
  logic       s1_is_read;
  logic [7:0] s1_read_addr;

  // parser state
  phase_t     phase, phase_next;
  logic [7:0] hdr0, hdr0_next;
  logic [7:0] hdr1, hdr1_next;
  logic [7:0] frame_id, frame_id_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] sum_acc, sum_acc_next;
  logic [7:0] param_offset, param_offset_next;
  logic [7:0] frame_status, frame_status_next;
  logic       echo_pending, echo_pending_next;
  logic [7:0] cur_read_addr, cur_read_addr_next;
  logic [7:0] pos_low, pos_low_next;
  logic [7:0] pos_high, pos_high_next;
  logic [1:0] pos_captured, pos_captured_next;
  logic [15:0] bad_count, bad_count_next;

  // per-slot stored results
  logic [15:0] pos_store  [NUM_SERVOS];
  logic [7:0]  stat_store [NUM_SERVOS];

  // result of the current request
  logic             res_valid;
  logic             res_ok;
  logic             res_echo;
  logic             res_matched;
  logic [IDX_W-1:0] res_idx;
  logic             res_updated;
  logic [15:0]      res_position;
  logic             store_write;

  // stage advances when the result register is free or being emptied
  logic advance;
  logic in_accept;

  assign advance   = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      servo_id[0] <= SERVO_ID_0_RESET;
      servo_id[1] <= SERVO_ID_1_RESET;
      servo_id[2] <= SERVO_ID_2_RESET;
      servo_id[3] <= SERVO_ID_3_RESET;
      pos_address <= POS_ADDRESS_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SERVO_ID_0:  servo_id[0] <= cfg_data;
        REG_SERVO_ID_1:  servo_id[1] <= cfg_data;
        REG_SERVO_ID_2:  servo_id[2] <= cfg_data;
        REG_SERVO_ID_3:  servo_id[3] <= cfg_data;
        REG_POS_ADDRESS: pos_address <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_mode      <= mode;
      s1_byte      <= rx_byte;
      s1_is_read   <= is_read_request;
      s1_read_addr <= read_address;
    end
  end

  // single-pass parser step for the request held in the input register
  always_comb begin
    logic [7:0]  pcount;
    logic [7:0]  offset_inc;
    logic [8:0]  param_addr;
    logic [7:0]  new_sum;
    logic        found;
    logic [IDX_W-1:0] idx;

    phase_next          = phase;
    hdr0_next           = hdr0;
    hdr1_next           = hdr1;
    frame_id_next       = frame_id;
    frame_length_next   = frame_length;
    sum_acc_next        = sum_acc;
    param_offset_next   = param_offset;
    frame_status_next   = frame_status;
    echo_pending_next   = echo_pending;
    cur_read_addr_next  = cur_read_addr;
    pos_low_next        = pos_low;
    pos_high_next       = pos_high;
    pos_captured_next   = pos_captured;
    bad_count_next      = bad_count;

    res_valid    = 1'b0;
    res_ok       = 1'b0;
    res_echo     = 1'b0;
    res_matched  = 1'b0;
    res_idx      = '0;
    res_updated  = 1'b0;
    res_position = '0;
    store_write  = 1'b0;

    // parameter bytes after the status byte; short lengths give none
    pcount     = (frame_length >= MIN_LENGTH) ? (frame_length - MIN_LENGTH) : 8'd0;
    offset_inc = param_offset + 8'd1;
    // addresses run past 255 without wrap, so above 256 they never match
    param_addr = {1'b0, cur_read_addr} + {1'b0, param_offset};
    new_sum    = sum_acc + s1_byte;

    // lowest matching slot wins
    found = 1'b0;
    idx   = '0;
    for (int i = NUM_SERVOS - 1; i >= 0; i--) begin
      if (servo_id[i] == frame_id) begin
        found = 1'b1;
        idx   = IDX_W'(i);
      end
    end

    if (s1_valid && s1_mode) begin
      // own transmit: next frame is our echo
      echo_pending_next = 1'b1;
      if (s1_is_read) begin
        cur_read_addr_next = s1_read_addr;
      end
    end else if (s1_valid) begin
      case (phase)
        PH_HUNT: begin
          hdr1_next = hdr0;
          hdr0_next = s1_byte;
          if (s1_byte == HEADER_BYTE && hdr0 == HEADER_BYTE) begin
            hdr0_next  = '0;
            hdr1_next  = '0;
            phase_next = PH_ID;
          end
        end
        PH_ID: begin
          frame_id_next = s1_byte;
          sum_acc_next  = s1_byte;
          phase_next    = PH_LEN;
        end
        PH_LEN: begin
          frame_length_next = s1_byte;
          sum_acc_next      = new_sum;
          phase_next        = PH_STATUS;
        end
        PH_STATUS: begin
          frame_status_next = s1_byte;
          sum_acc_next      = new_sum;
          param_offset_next = '0;
          pos_captured_next = 2'd0;
          pos_low_next      = '0;
          pos_high_next     = '0;
          phase_next        = (pcount != 8'd0) ? PH_PARAM : PH_CSUM;
        end
        PH_PARAM: begin
          if (pos_captured == 2'd0 && param_addr == {1'b0, pos_address}) begin
            pos_low_next      = s1_byte;
            pos_captured_next = 2'd1;
          end else if (pos_captured == 2'd1 &&
                       param_addr == ({1'b0, pos_address} + 9'd1)) begin
            pos_high_next     = s1_byte;
            pos_captured_next = 2'd2;
          end
          sum_acc_next      = new_sum;
          param_offset_next = offset_inc;
          if (offset_inc >= pcount) begin
            phase_next = PH_CSUM;
          end
        end
        PH_CSUM: begin
          res_valid = 1'b1;
          res_ok    = (~sum_acc == s1_byte);
          res_echo  = echo_pending;
          if (!res_ok) begin
            if (bad_count != BAD_COUNT_MAX) begin
              bad_count_next = bad_count + 16'd1;
            end
          end else if (!echo_pending && found) begin
            res_matched = 1'b1;
            res_idx     = idx;
            store_write = 1'b1;
            res_updated = (pos_captured == 2'd2);
          end
          res_position = res_updated ? {pos_high, pos_low} : pos_store[idx];
          echo_pending_next = 1'b0;
          phase_next        = PH_HUNT;
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  // parser state registers, stepped when the stage advances
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      hdr0          <= '0;
      hdr1          <= '0;
      frame_id      <= '0;
      frame_length  <= '0;
      sum_acc       <= '0;
      param_offset  <= '0;
      frame_status  <= '0;
      echo_pending  <= 1'b0;
      cur_read_addr <= '0;
      pos_low       <= '0;
      pos_high      <= '0;
      pos_captured  <= 2'd0;
      bad_count     <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      hdr0          <= hdr0_next;
      hdr1          <= hdr1_next;
      frame_id      <= frame_id_next;
      frame_length  <= frame_length_next;
      sum_acc       <= sum_acc_next;
      param_offset  <= param_offset_next;
      frame_status  <= frame_status_next;
      echo_pending  <= echo_pending_next;
      cur_read_addr <= cur_read_addr_next;
      pos_low       <= pos_low_next;
      pos_high      <= pos_high_next;
      pos_captured  <= pos_captured_next;
      bad_count     <= bad_count_next;
    end
  end

  // per-slot status and position store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SERVOS; i++) begin
        pos_store[i]  <= '0;
        stat_store[i] <= '0;
      end
    end else if (advance && store_write) begin
      stat_store[res_idx] <= frame_status;
      if (res_updated) begin
        pos_store[res_idx] <= {pos_high, pos_low};
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      checksum_ok      <= res_ok;
      was_echo         <= res_echo;
      servo_matched    <= res_matched;
      servo_index      <= res_matched ? 2'(res_idx) : 2'd0;
      servo_status     <= res_matched ? frame_status : 8'd0;
      position_updated <= res_updated;
      position         <= res_matched ? res_position : 16'd0;
      failed_checksums <= bad_count_next;
    end
  end

  // a checksum byte that moves on always produces a result and rearms the hunt
  a_csum_result : assert property (@(posedge clk) disable iff (rst)
    (advance && s1_valid && !s1_mode && phase == PH_CSUM) |=>
      (out_valid && phase == PH_HUNT))
    else $error("checksum byte did not produce a result");

  // the bad checksum count never goes down outside reset
  a_count_monotonic : assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (bad_count >= $past(bad_count)))
    else $error("bad checksum count decreased");

  // a position update needs a good, matched, non-echo frame
  a_update_qualified : assert property (@(posedge clk) disable iff (rst)
    (out_valid && position_updated) |-> (checksum_ok && servo_matched && !was_echo))
    else $error("position update on an unqualified frame");

endmodule
